[src/block_sparse_row_vector_product_macros.svh]
// assertion macros shared by the block-sparse row product design
`ifndef BLOCK_SPARSE_ROW_VECTOR_PRODUCT_MACROS_SVH
`define BLOCK_SPARSE_ROW_VECTOR_PRODUCT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSRVP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSRVP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/bsrvp_pkg.sv]
// shared types and constants of the block-sparse row product design
package bsrvp_pkg;

	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;
	localparam int ADDR_W = 12;
	localparam int BCOL_W = 12;
	localparam int ROW_W  = 3;
	localparam int BS_W   = 4;
	// widest vector index: 4095 * 8 + 7
	localparam int IDX_W  = 15;

	localparam int DEF_VEC_DEPTH = 4096;
	localparam int DEF_MAX_BLOCK = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// configuration register indexes, taken from paddr[2]
	localparam logic REG_IDX_BLOCK_SIZE    = 1'b0;
	localparam logic REG_IDX_MIN_BLOCK_COL = 1'b1;

	// input item codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ENTRY = 1'b1;

	// one classified operation for the back end
	typedef struct packed {
		logic              wr_en;    // load into vector memory
		logic              acc_en;   // multiply and accumulate
		logic              err;      // vector index past memory
		logic              row_end;  // close the block row
		logic [ROW_W-1:0]  row;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  value;
	} op_t;

endpackage

[src/bsrvp_front.sv]
// front end: classifies input items into back-end operations
module bsrvp_front import bsrvp_pkg::*; #(
	parameter int VEC_DEPTH = DEF_VEC_DEPTH
) (
	input  logic              req_type,
	input  logic [ADDR_W-1:0] vec_addr,
	input  logic [BCOL_W-1:0] block_col,
	input  logic [2:0]        col_in_block,
	input  logic [ROW_W-1:0]  row_in_block,
	input  logic [VAL_W-1:0]  value,
	input  logic              row_end,
	input  logic [BS_W-1:0]   eff_bs,
	input  logic [BCOL_W-1:0] min_block_col,
	output op_t               op
);

	localparam logic [31:0] DEPTH_U = 32'(VEC_DEPTH);

	logic [15:0] vi;
	logic        in_block;
	logic        vi_ok;
	logic        load_ok;

	assign vi       = 16'(block_col) * 16'(eff_bs) + 16'(col_in_block);
	assign in_block = (block_col >= min_block_col)
		&& (BS_W'(col_in_block) < eff_bs) && (BS_W'(row_in_block) < eff_bs);
	assign vi_ok    = 32'(vi) < DEPTH_U;
	assign load_ok  = 32'(vec_addr) < DEPTH_U;

	always_comb begin
		op         = '0;
		op.row     = row_in_block;
		op.value   = value;
		if (req_type == REQ_LOAD) begin
			op.wr_en = load_ok;
			op.idx   = IDX_W'(vec_addr);
		end else begin
			op.idx     = vi[IDX_W-1:0];
			op.acc_en  = in_block && vi_ok;
			op.err     = in_block && !vi_ok;
			op.row_end = row_end;
		end
	end

endmodule

[src/bsrvp_fifo.sv]
// short operation queue between front and back end
module bsrvp_fifo import bsrvp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  op_t  wr_data,
	output logic full,
	input  logic rd_en,
	output op_t  rd_data,
	output logic rd_valid
);

	op_t               slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = slot_q[head_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				tail_q <= tail_q + 1'b1;
			if (do_rd)
				head_q <= head_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[tail_q] <= wr_data;
	end

endmodule

[src/bsrvp_back.sv]
// back end: vector memory, multiply, saturating accumulate and row drain
module bsrvp_back import bsrvp_pkg::*; #(
	parameter int VEC_DEPTH = DEF_VEC_DEPTH,
	parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BS_W-1:0]   eff_bs,
	input  op_t               op,
	input  logic              op_valid,
	output logic              op_take,
	output logic              empty,
	input  logic              pop,
	output logic [ROW_W-1:0]  lane,
	output logic [SUM_W-1:0]  sum,
	output logic              range_error,
	output logic              last
);

	localparam int AW = $clog2(VEC_DEPTH);
	localparam int IW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = a + b;
		if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1])
			s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return s;
	endfunction

	logic [VAL_W-1:0] mem [VEC_DEPTH];
	logic [AW-1:0]    maddr;

	op_t              op_s1;
	op_t              op_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic [VAL_W-1:0] rd_s1;
	logic signed [SUM_W-1:0] prod_s2;

	logic [SUM_W-1:0] acc_q  [MAX_BLOCK];
	logic [SUM_W-1:0] snap_q [MAX_BLOCK];
	logic             err_q;
	logic             snap_err_q;
	logic             busy_q;
	logic [ROW_W-1:0] lane_q;

	logic [SUM_W-1:0] sum_new;
	logic             adv;
	logic             close_row;
	logic             drain_done;

	assign maddr      = AW'(op.idx);
	assign last       = ({1'b0, lane_q} + 1'b1) == eff_bs;
	assign drain_done = pop && busy_q && last;
	assign adv        = !(valid_s2 && op_s2.row_end) || !busy_q || drain_done;
	assign close_row  = adv && valid_s2 && op_s2.row_end;
	assign op_take    = adv && op_valid;
	assign sum_new    = sat_add(acc_q[op_s2.row[IW-1:0]], prod_s2);

	// vector memory, one access per operation
	always_ff @(posedge clk) begin
		if (op_take) begin
			if (op.wr_en)
				mem[maddr] <= op.value;
			rd_s1 <= mem[maddr];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op;
			op_s2   <= op_s1;
			prod_s2 <= $signed(op_s1.value) * $signed(rd_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			err_q    <= 1'b0;
			busy_q   <= 1'b0;
			lane_q   <= '0;
			acc_q    <= '{default: '0};
		end else begin
			if (adv) begin
				valid_s1 <= op_valid;
				valid_s2 <= valid_s1;
			end
			if (close_row) begin
				// a new row takes over the drain registers
				acc_q  <= '{default: '0};
				err_q  <= 1'b0;
				busy_q <= 1'b1;
				lane_q <= '0;
			end else begin
				if (pop && busy_q) begin
					if (last)
						busy_q <= 1'b0;
					else
						lane_q <= lane_q + 1'b1;
				end
				if (adv && valid_s2) begin
					if (op_s2.acc_en)
						acc_q[op_s2.row[IW-1:0]] <= sum_new;
					if (op_s2.err)
						err_q <= 1'b1;
				end
			end
		end
	end

	// finished row, held until every lane is taken
	always_ff @(posedge clk) begin
		if (close_row) begin
			snap_err_q <= err_q || op_s2.err;
			for (int k = 0; k < MAX_BLOCK; k++)
				snap_q[IW'(k)] <= (op_s2.acc_en && op_s2.row == ROW_W'(k)) ?
					sum_new : acc_q[IW'(k)];
		end
	end

	assign empty       = !busy_q;
	assign lane        = lane_q;
	assign sum         = snap_q[lane_q[IW-1:0]];
	assign range_error = snap_err_q;

endmodule

[src/block_sparse_row_vector_product.sv]
// top level of the block-sparse row times dense vector product
//
// usage: load the dense vector with load transactions (req_type 0, vec_addr,
// value), then stream the nonzero entries of one block row (req_type 1).
// each entry adds value * vector[block_col*block_size + col_in_block] into
// the accumulator of row_in_block with Q32.32 saturation; the entry marked
// row_end closes the row and yields block_size result transactions, lane 0
// first, last set on the final one, range_error set if any index ran past
// the vector memory. configure block_size and min_block_col over the apb
// port while the block is idle.
// throughput: one input transaction per cycle, set by one vector memory
// access and one multiply-accumulate per entry. a row end that reaches the
// back end while the previous row is still draining holds it until that
// row's last sum is popped. a row_end transaction passes through the queue
// and the op_s1 and op_s2 registers, and its row is closed into the snapshot
// registers that offer the first sum. when pop stays low the back end
// fills, the queue fills and full rises. reset clears the accumulators, the
// error flag and the queues; vector memory contents stay undefined until loaded.
module block_sparse_row_vector_product import bsrvp_pkg::*; #(
	parameter int VEC_DEPTH = DEF_VEC_DEPTH,
	parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// apb configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input transactions
	input  logic                    push,
	output logic                    full,
	input  logic                    req_type,
	input  logic [ADDR_W-1:0]       vec_addr,
	input  logic [BCOL_W-1:0]       block_col,
	input  logic [2:0]              col_in_block,
	input  logic [ROW_W-1:0]        row_in_block,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    row_end,
	// result transactions
	output logic                    empty,
	input  logic                    pop,
	output logic [ROW_W-1:0]        lane,
	output logic signed [SUM_W-1:0] sum,
	output logic                    range_error,
	output logic                    last
);

`include "block_sparse_row_vector_product_macros.svh"

	localparam logic [BS_W-1:0] MAX_BS = BS_W'(MAX_BLOCK);

	logic [BS_W-1:0]   block_size_q;
	logic [BCOL_W-1:0] min_block_col_q;
	logic [BS_W-1:0]   eff_bs;
	logic              cfg_wr;

	op_t               front_op;
	op_t               queue_op;
	logic              queue_valid;
	logic              queue_take;
	logic [SUM_W-1:0]  sum_raw;

	// configuration registers; pready is tied high, no wait states
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q    <= BS_W'(1);
			min_block_col_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IDX_BLOCK_SIZE:    block_size_q    <= pwdata[BS_W-1:0];
				REG_IDX_MIN_BLOCK_COL: min_block_col_q <= pwdata[BCOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IDX_BLOCK_SIZE:    prdata = 32'(block_size_q);
			REG_IDX_MIN_BLOCK_COL: prdata = 32'(min_block_col_q);
			default:               prdata = '0;
		endcase
	end

	// zero block size acts as one, oversize is clamped to the lane count
	always_comb begin
		if (block_size_q == '0)
			eff_bs = BS_W'(1);
		else if (block_size_q > MAX_BS)
			eff_bs = MAX_BS;
		else
			eff_bs = block_size_q;
	end

	// front end classifies each transaction as it is pushed
	bsrvp_front #(
		.VEC_DEPTH(VEC_DEPTH)
	) u_front (
		.req_type     (req_type),
		.vec_addr     (vec_addr),
		.block_col    (block_col),
		.col_in_block (col_in_block),
		.row_in_block (row_in_block),
		.value        (value),
		.row_end      (row_end),
		.eff_bs       (eff_bs),
		.min_block_col(min_block_col_q),
		.op           (front_op)
	);

	// decoupling queue: full here is the input backpressure
	bsrvp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (front_op),
		.full    (full),
		.rd_en   (queue_take),
		.rd_data (queue_op),
		.rd_valid(queue_valid)
	);

	// back end: memory read, multiply, accumulate, drain one lane per pop
	bsrvp_back #(
		.VEC_DEPTH(VEC_DEPTH),
		.MAX_BLOCK(MAX_BLOCK)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eff_bs     (eff_bs),
		.op         (queue_op),
		.op_valid   (queue_valid),
		.op_take    (queue_take),
		.empty      (empty),
		.pop        (pop),
		.lane       (lane),
		.sum        (sum_raw),
		.range_error(range_error),
		.last       (last)
	);

	assign sum = $signed(sum_raw);

	// a taken non-final sum is followed by the next lane of the same row
	`BSRVP_ASSERT_NEXT(a_lane_step, pop && !empty && !last,
		!empty && lane == $past(lane) + 3'd1, "lane did not advance after a non-final sum")

	// after the final sum either nothing waits or a fresh row starts at lane 0
	`BSRVP_ASSERT_NEXT(a_row_restart, pop && !empty && last,
		empty || lane == '0, "new row did not start at lane zero")

	// the back end never takes an operation from an empty queue
	`BSRVP_ASSERT_NOW(a_take_valid, queue_take, queue_valid,
		"operation taken from an empty queue")

endmodule
